// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies a result in the next one.
`define ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== rtl/fbpa_pkg.sv =====
// Shared types and constants of the fixed block pool allocator.
// Used by every module of the block; depends on nothing else.
package fbpa_pkg;

    // Fixed field widths of the request and result beats.
    localparam int IDX_PORT_W = 6;
    localparam int ESZ_W      = 13;
    localparam int OFF_W      = 18;
    localparam int PROD_W     = ESZ_W + IDX_PORT_W;

    localparam logic [ESZ_W-1:0] ESZ_RESET = 13'd8;

    // Request type codes.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    // Free list operations for one cycle.
    typedef struct packed {
        logic pop;
        logic push;
    } list_ctrl_t;

endpackage

// ===== rtl/fbpa_free_list.sv =====
// LIFO free list of the allocator: head register, link memory and link prefetch.
// Depends on fbpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbpa_free_list #(
    parameter int IDX_W = 6,
    parameter int PTR_W = 7,
    parameter int POOL_BLOCKS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fbpa_pkg::list_ctrl_t   ctrl,
    input  logic [IDX_W-1:0]       push_idx,
    output logic [PTR_W-1:0]       head,
    output logic                   empty
);

    localparam int MEM_DEPTH = 2 ** IDX_W;

    logic [PTR_W-1:0] link_mem [MEM_DEPTH];

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] link_reg, link_next;
    logic             link_sel_reg, link_sel_next;
    logic [PTR_W-1:0] rd_data_reg;
    logic [PTR_W-1:0] link_eff;

    // The link of the current head comes from the memory right after a pop.
    assign link_eff = link_sel_reg ? rd_data_reg : link_reg;

    assign head  = head_reg;
    assign empty = (head_reg >= PTR_W'(POOL_BLOCKS));

    // Next head and cached link for push, pop and hold.
    always_comb
    begin
        head_next     = head_reg;
        link_next     = link_eff;
        link_sel_next = 1'b0;
        if (ctrl.push)
        begin
            head_next = PTR_W'(push_idx);
            link_next = head_reg;
        end
        else if (ctrl.pop)
        begin
            head_next     = link_eff;
            link_sel_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= PTR_W'(POOL_BLOCKS);
            link_reg     <= '0;
            link_sel_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            link_reg     <= link_next;
            link_sel_reg <= link_sel_next;
        end
    end

    // Link memory: a push writes the old head; the link of the next head is
    // read every cycle so that a pop can be followed by another pop.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            link_mem[push_idx] <= head_reg;
        end
        rd_data_reg <= link_mem[link_eff[IDX_W-1:0]];
    end

    `ASSERT_CLK(a_pop_not_empty, clk, rst_n, !(ctrl.pop && empty), "pop from empty free list")
    `ASSERT_CLK(a_one_op, clk, rst_n, !(ctrl.pop && ctrl.push), "push and pop in one cycle")
    `ASSERT_NEXT(a_push_head, clk, rst_n, ctrl.push, head_reg == $past(PTR_W'(push_idx)), "push did not set head")

endmodule

// ===== rtl/fbpa_result.sv =====
// Result register of the allocator: scales the granted index to a byte offset.
// Depends on fbpa_pkg.
module fbpa_result (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             valid_in,
    input  fbpa_pkg::status_t                status_in,
    input  logic [fbpa_pkg::IDX_PORT_W-1:0]  index_in,
    input  logic [fbpa_pkg::ESZ_W-1:0]       elem_size,
    output logic                             done,
    output fbpa_pkg::status_t                status,
    output logic [fbpa_pkg::IDX_PORT_W-1:0]  granted_index,
    output logic [fbpa_pkg::OFF_W-1:0]       block_offset
);

    logic [fbpa_pkg::PROD_W-1:0] product;
    logic                        done_reg;
    fbpa_pkg::status_t           status_reg;
    logic [fbpa_pkg::IDX_PORT_W-1:0] index_reg;
    logic [fbpa_pkg::OFF_W-1:0]  offset_reg;

    // Byte offset; a failed request carries index 0 and so offset 0.
    assign product = fbpa_pkg::PROD_W'(elem_size) * fbpa_pkg::PROD_W'(index_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_in;
        index_reg  <= index_in;
        offset_reg <= product[fbpa_pkg::OFF_W-1:0];
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_index = index_reg;
    assign block_offset  = offset_reg;

endmodule

// ===== rtl/fixed_block_pool_allocator.sv =====
// Top level of the fixed block pool allocator: request register, bump pointer,
// free list and result register. Depends on fbpa_pkg, fbpa_free_list, fbpa_result.
//
// Usage:
//   A request beat (req_type, block_index) is taken at a rising edge with start
//   high and busy low. busy stays low: a request may be issued every cycle.
//   An allocate hands out the block at the bump pointer while untouched blocks
//   remain, then pops the head of the free list, else reports out of memory.
//   A free pushes block_index onto the free list, or reports an invalid free
//   for a block that was never handed out.
//   Each request gives exactly one result beat on status, granted_index and
//   block_offset, marked by done for one cycle. A request passes through the
//   request register and then the result register, which drives done and the
//   beat. Throughput is one request per cycle; the free
//   list keeps the link of its head prefetched from the link memory so that
//   pops can follow each other.
//   The receiver cannot stall; results must be taken when done is high.
//   elem_size is written through cfg_we/cfg_data while no request is in flight.
//   Reset empties the pool: bump pointer zero, free list empty, elem_size 8.
`include "assert_macros.svh"

module fixed_block_pool_allocator #(
    parameter int POOL_BLOCKS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                req_type,
    input  logic [fbpa_pkg::IDX_PORT_W-1:0]     block_index,
    input  logic                                cfg_we,
    input  logic [fbpa_pkg::ESZ_W-1:0]          cfg_data,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [fbpa_pkg::IDX_PORT_W-1:0]     granted_index,
    output logic [fbpa_pkg::OFF_W-1:0]          block_offset
);

    localparam int IDX_W = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam int PTR_W = $clog2(POOL_BLOCKS + 1);
    localparam int CMP_W = (PTR_W > fbpa_pkg::IDX_PORT_W) ? PTR_W : fbpa_pkg::IDX_PORT_W;

    logic                              in_valid_reg;
    logic                              in_type_reg;
    logic [fbpa_pkg::IDX_PORT_W-1:0]   in_idx_reg;
    logic [fbpa_pkg::ESZ_W-1:0]        elem_size_reg;
    logic [PTR_W-1:0]                  bump_reg, bump_next;

    fbpa_pkg::list_ctrl_t              list_ctrl;
    logic [PTR_W-1:0]                  list_head;
    logic                              list_empty;

    logic                              is_alloc, is_free;
    logic                              bump_avail, do_bump, do_pop, out_of_mem;
    logic                              bad_free;
    logic [CMP_W-1:0]                  idx_ext, grant_ext;
    fbpa_pkg::status_t                 res_status;

    assign busy = 1'b0;

    // Request register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_type_reg <= req_type;
            in_idx_reg  <= block_index;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_size_reg <= fbpa_pkg::ESZ_RESET;
        end
        else if (cfg_we)
        begin
            elem_size_reg <= cfg_data;
        end
    end

    // Request decode: bump pointer first, then the free list.
    assign is_alloc   = in_valid_reg && (in_type_reg == fbpa_pkg::REQ_ALLOC);
    assign is_free    = in_valid_reg && (in_type_reg == fbpa_pkg::REQ_FREE);
    assign bump_avail = (bump_reg < PTR_W'(POOL_BLOCKS));
    assign do_bump    = is_alloc && bump_avail;
    assign do_pop     = is_alloc && !bump_avail && !list_empty;
    assign out_of_mem = is_alloc && !bump_avail && list_empty;

    // A free is valid only for a block below the bump pointer.
    assign idx_ext  = CMP_W'(in_idx_reg);
    assign bad_free = is_free && ((idx_ext >= CMP_W'(bump_reg))
                                  || (idx_ext >= CMP_W'(POOL_BLOCKS)));

    assign list_ctrl.pop  = do_pop;
    assign list_ctrl.push = is_free && !bad_free;

    assign bump_next = do_bump ? bump_reg + PTR_W'(1) : bump_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bump_reg <= '0;
        end
        else
        begin
            bump_reg <= bump_next;
        end
    end

    // Granted index and status of the result beat.
    always_comb
    begin
        grant_ext  = '0;
        res_status = fbpa_pkg::ST_OK;
        if (do_bump)
        begin
            grant_ext = CMP_W'(bump_reg);
        end
        else if (do_pop)
        begin
            grant_ext = CMP_W'(list_head);
        end
        else if (list_ctrl.push)
        begin
            grant_ext = idx_ext;
        end
        if (out_of_mem)
        begin
            res_status = fbpa_pkg::ST_OOM;
        end
        else if (bad_free)
        begin
            res_status = fbpa_pkg::ST_BAD_FREE;
        end
    end

    fbpa_free_list #(
        .IDX_W       (IDX_W),
        .PTR_W       (PTR_W),
        .POOL_BLOCKS (POOL_BLOCKS)
    ) u_free_list (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (list_ctrl),
        .push_idx (idx_ext[IDX_W-1:0]),
        .head     (list_head),
        .empty    (list_empty)
    );

    fbpa_pkg::status_t result_status;

    fbpa_result u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .valid_in      (in_valid_reg),
        .status_in     (res_status),
        .index_in      (grant_ext[fbpa_pkg::IDX_PORT_W-1:0]),
        .elem_size     (elem_size_reg),
        .done          (done),
        .status        (result_status),
        .granted_index (granted_index),
        .block_offset  (block_offset)
    );

    assign status = result_status;

    `ASSERT_NEXT(a_one_result, clk, rst_n, in_valid_reg, done, "request without result beat")
    `ASSERT_CLK(a_bump_range, clk, rst_n, bump_reg <= PTR_W'(POOL_BLOCKS), "bump pointer past pool")
    `ASSERT_CLK(a_pop_after_bump, clk, rst_n, !(do_pop && bump_avail), "free list used before bump pool is spent")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for fixed_block_pool_allocator: random request beats
// with random idle gaps, checked against a scoreboard that tracks the pool state.
// Depends on fbpa_pkg and the allocator RTL.
module tb_top;

    localparam int POOL   = 64;
    localparam int IDX_W  = fbpa_pkg::IDX_PORT_W;
    localparam int ESZ_W  = fbpa_pkg::ESZ_W;
    localparam int OFF_W  = fbpa_pkg::OFF_W;
    localparam int PROD_W = fbpa_pkg::PROD_W;

    // Drain mostly allocates, refill mostly frees held blocks, mixed is even.
    localparam int MODE_DRAIN  = 0;
    localparam int MODE_REFILL = 1;
    localparam int MODE_MIXED  = 2;

    typedef struct packed {
        fbpa_pkg::status_t      st;
        logic [IDX_W-1:0]       idx;
        logic [OFF_W-1:0]       off;
    } grant_beat_t;

    // Scoreboard: keeps its own copy of the pool state and the expected beats.
    class alloc_scoreboard;
        logic [ESZ_W-1:0]  elem_size;
        logic [6:0]        bump_ptr;
        logic [6:0]        head;
        logic [6:0]        link [POOL];
        grant_beat_t       grant_q[$];
        int                fail_count;
        int                n_bump;
        int                n_pop;
        int                n_oom;
        int                n_free;
        int                n_bad_free;
        int                n_checked;

        function new();
            elem_size  = fbpa_pkg::ESZ_RESET;
            bump_ptr   = '0;
            head       = 7'(POOL);
            fail_count = 0;
            n_bump     = 0;
            n_pop      = 0;
            n_oom      = 0;
            n_free     = 0;
            n_bad_free = 0;
            n_checked  = 0;
        endfunction

        function void set_elem_size(logic [ESZ_W-1:0] v);
            elem_size = v;
        endfunction

        // Build a result beat; the offset wraps to the port width.
        function grant_beat_t make_beat(fbpa_pkg::status_t st, logic [IDX_W-1:0] idx);
            grant_beat_t       b;
            logic [PROD_W-1:0] prod;
            prod  = PROD_W'(elem_size) * PROD_W'(idx);
            b.st  = st;
            b.idx = idx;
            b.off = prod[OFF_W-1:0];
            return b;
        endfunction

        // Apply one accepted request to the pool state and queue its result.
        function grant_beat_t note_request(logic req, logic [IDX_W-1:0] idx);
            grant_beat_t b;
            logic [6:0]  g;
            if (req == fbpa_pkg::REQ_ALLOC)
            begin
                if (bump_ptr < POOL)
                begin
                    g        = bump_ptr;
                    bump_ptr = bump_ptr + 7'd1;
                    b        = make_beat(fbpa_pkg::ST_OK, g[IDX_W-1:0]);
                    n_bump++;
                end
                else if (head < POOL)
                begin
                    g    = head;
                    head = link[g[IDX_W-1:0]];
                    b    = make_beat(fbpa_pkg::ST_OK, g[IDX_W-1:0]);
                    n_pop++;
                end
                else
                begin
                    b = make_beat(fbpa_pkg::ST_OOM, '0);
                    n_oom++;
                end
            end
            else
            begin
                if ({1'b0, idx} >= bump_ptr)
                begin
                    b = make_beat(fbpa_pkg::ST_BAD_FREE, '0);
                    n_bad_free++;
                end
                else
                begin
                    link[idx] = head;
                    head      = {1'b0, idx};
                    b         = make_beat(fbpa_pkg::ST_OK, idx);
                    n_free++;
                end
            end
            grant_q.push_back(b);
            return b;
        endfunction

        // Compare one result beat with the oldest expected beat.
        function void check_beat(logic [1:0] st, logic [IDX_W-1:0] idx,
                                 logic [OFF_W-1:0] off);
            grant_beat_t e;
            if (grant_q.size() == 0)
            begin
                $error("unexpected result beat: status %0d index %0d offset %0d",
                       st, idx, off);
                fail_count++;
                return;
            end
            e = grant_q.pop_front();
            n_checked++;
            if (st !== e.st)
            begin
                $error("status: expected %0d, actual %0d", e.st, st);
                fail_count++;
            end
            if (idx !== e.idx)
            begin
                $error("granted_index: expected %0d, actual %0d", e.idx, idx);
                fail_count++;
            end
            if (off !== e.off)
            begin
                $error("block_offset: expected %0d, actual %0d", e.off, off);
                fail_count++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    req_type;
    logic [IDX_W-1:0]        block_index;
    logic                    cfg_we;
    logic [ESZ_W-1:0]        cfg_data;
    logic                    done;
    logic [1:0]              status;
    logic [IDX_W-1:0]        granted_index;
    logic [OFF_W-1:0]        block_offset;

    alloc_scoreboard         sb;
    grant_beat_t             last_beat;
    logic [IDX_W-1:0]        held[$];
    int                      n_sizes;

    fixed_block_pool_allocator #(
        .POOL_BLOCKS(POOL)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .block_index   (block_index),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .done          (done),
        .status        (status),
        .granted_index (granted_index),
        .block_offset  (block_offset)
    );

    // 4 ns clock.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result monitor: every done beat is checked at the edge that takes it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_beat(status, granted_index, block_offset);
    end

    // Issue one request beat after an idle gap; returns at the next falling edge.
    task automatic do_request(input logic req, input logic [IDX_W-1:0] idx,
                              input int gap);
        int k;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        req_type    <= req;
        block_index <= idx;
        do
            @(posedge clk);
        while (busy);
        last_beat = sb.note_request(req, idx);
        // Track which blocks the traffic currently owns.
        if (last_beat.st == fbpa_pkg::ST_OK)
        begin
            if (req == fbpa_pkg::REQ_ALLOC)
                held.push_back(last_beat.idx);
            else
            begin
                for (k = 0; k < held.size(); k++)
                begin
                    if (held[k] == idx)
                    begin
                        held.delete(k);
                        break;
                    end
                end
            end
        end
        @(negedge clk);
    endtask

    // One random beat: mostly well-formed traffic, some frees of random blocks.
    task automatic rand_item(input int mode, input int gap);
        int r;
        int alloc_pct;
        r = $urandom_range(0, 99);
        alloc_pct = (mode == MODE_DRAIN) ? 85 : (mode == MODE_REFILL) ? 15 : 50;
        if (r < 10)
            do_request(fbpa_pkg::REQ_FREE, IDX_W'($urandom), gap);
        else if ($urandom_range(0, 99) < alloc_pct)
            do_request(fbpa_pkg::REQ_ALLOC, IDX_W'($urandom), gap);
        else if (held.size() > 0)
            do_request(fbpa_pkg::REQ_FREE, held[$urandom_range(0, held.size() - 1)], gap);
        else
            do_request(fbpa_pkg::REQ_FREE, IDX_W'($urandom), gap);
    endtask

    // Run random beats in segments, each with its own idling and, unless a fixed mode is given, its own traffic mix.
    task automatic rand_phase(input int n_items, input int fixed_mode);
        int i;
        int mode;
        int idle_mode;
        mode      = fixed_mode;
        idle_mode = 0;
        for (i = 0; i < n_items; i++)
        begin
            if (i % 25 == 0)
            begin
                if (fixed_mode < 0)
                    mode = $urandom_range(MODE_DRAIN, MODE_MIXED);
                idle_mode = $urandom_range(0, 2);
            end
            rand_item(mode, (idle_mode == 0) ? 0 : $urandom_range(0, 9));
        end
    endtask

    // Change elem_size once every expected beat is back and the pipeline is empty.
    task automatic write_elem_size(input logic [ESZ_W-1:0] v);
        start <= 1'b0;
        while (sb.grant_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_elem_size(v);
        n_sizes++;
    endtask

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence.
    initial
    begin
        logic [ESZ_W-1:0] esz_list [7];
        int               p;
        int               n;
        int               oom_seen;
        esz_list    = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd0, 13'd8, 13'd0};
        esz_list[4] = 13'($urandom_range(1, 4096));
        esz_list[6] = 13'($urandom);
        sb          = new();
        n_sizes     = 1;
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = fbpa_pkg::REQ_ALLOC;
        block_index = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: invalid frees on a fresh pool, bump grants, double free.
        do_request(fbpa_pkg::REQ_FREE, 6'd0, 0);
        do_request(fbpa_pkg::REQ_FREE, 6'd63, 0);
        do_request(fbpa_pkg::REQ_ALLOC, 6'd63, 0);
        do_request(fbpa_pkg::REQ_ALLOC, 6'd0, 0);
        do_request(fbpa_pkg::REQ_FREE, 6'd2, 0);
        do_request(fbpa_pkg::REQ_FREE, 6'd63, 0);
        do_request(fbpa_pkg::REQ_FREE, 6'd1, 0);
        do_request(fbpa_pkg::REQ_FREE, 6'd1, 0);
        do_request(fbpa_pkg::REQ_FREE, 6'd0, 0);
        do_request(fbpa_pkg::REQ_ALLOC, 6'd42, 0);
        do_request(fbpa_pkg::REQ_FREE, 6'd3, 1);

        // Early random traffic while untouched blocks remain.
        rand_phase(150, MODE_MIXED);

        // Allocate back to back until the pool runs dry twice, then give all back.
        oom_seen = 0;
        n        = 0;
        while (oom_seen < 2 && n < 200)
        begin
            do_request(fbpa_pkg::REQ_ALLOC, IDX_W'($urandom), 0);
            if (last_beat.st == fbpa_pkg::ST_OOM)
                oom_seen++;
            n++;
        end
        while (held.size() > 0)
            do_request(fbpa_pkg::REQ_FREE, held[$urandom_range(0, held.size() - 1)],
                       $urandom_range(0, 2));

        // Random phases over several element sizes, extremes included.
        for (p = 0; p < 7; p++)
        begin
            write_elem_size(esz_list[p]);
            rand_phase(190, -1);
        end

        // Drain the pipeline and let any stray beat show up.
        start <= 1'b0;
        n = 0;
        while (sb.grant_q.size() != 0 && n < 200)
        begin
            @(posedge clk);
            n++;
        end
        repeat (8) @(posedge clk);
        if (sb.grant_q.size() != 0)
        begin
            $error("%0d expected result beats never arrived", sb.grant_q.size());
            sb.fail_count++;
        end

        $display("Checked %0d beats: %0d bump grants, %0d free-list grants, %0d out of memory,",
                 sb.n_checked, sb.n_bump, sb.n_pop, sb.n_oom);
        $display("%0d frees, %0d invalid frees, across %0d element sizes.",
                 sb.n_free, sb.n_bad_free, n_sizes);
        if (sb.fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
